// ===== hdl/fbm_pkg.sv =====
// Shared constants and types for the 3D fractal value noise pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package fbm_pkg;

    localparam int MAX_OCTAVES = 8;
    localparam int FRAC_BITS   = 16;
    localparam int POS_W       = 32 + FRAC_BITS;
    localparam int ACC_W       = 32;
    localparam int CV_W        = 24;
    localparam int WGT_W       = FRAC_BITS + 1;
    localparam int QUO_W       = 17;

    localparam logic [31:0] HASH_MUL_X = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
    localparam logic [31:0] HASH_MUL_Z = 32'd2147483647;
    localparam logic [31:0] HASH_MUL_S = 32'd144665;
    localparam logic [31:0] HASH_MIX   = 32'd1274126177;
    localparam logic [17:0] SCALE_Q16  = 18'd133038;
    localparam logic [31:0] SEED_STEP  = 32'd101;
    localparam logic [23:0] CORNER_MAX = 24'hffffff;

    localparam logic [0:0] REG_NOISE_SEED   = 1'b0;
    localparam logic [0:0] REG_OCTAVE_COUNT = 1'b1;

    // One item as it moves from octave to octave.
    typedef struct packed {
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic [POS_W-1:0] pz;
        logic [ACC_W-1:0] acc;
    } oct_bus_t;

endpackage

`default_nettype wire

// ===== hdl/fbm_octave.sv =====
// One noise octave: lattice hash, smoothstep, trilinear blend, Horner accumulate.
// Six register stages. Depends on fbm_pkg.
`default_nettype none

module fbm_octave (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_vld,
    input  fbm_pkg::oct_bus_t in_bus,
    input  logic [31:0]      seed,
    input  logic             active,
    output logic             out_vld,
    output fbm_pkg::oct_bus_t out_bus
);
    import fbm_pkg::*;

    function automatic logic [CV_W-1:0] blend(input logic [CV_W-1:0] a,
                                              input logic [CV_W-1:0] b,
                                              input logic [WGT_W-1:0] t);
        logic [41:0] s;
        s = 42'(a) * 42'(WGT_W'(1 << FRAC_BITS) - t) + 42'(b) * 42'(t);
        return s[FRAC_BITS +: CV_W];
    endfunction

    function automatic logic [POS_W-1:0] scale_pos(input logic [POS_W-1:0] p);
        logic [33:0] ph;
        logic [49:0] pl;
        ph = 34'(p[POS_W-1:32]) * 34'(SCALE_Q16);
        pl = 50'(p[31:0]) * 50'(SCALE_Q16);
        return {ph[31:0], 16'b0} + POS_W'(pl[49:16]);
    endfunction

    logic [5:0] vld_reg;

    // Stage A: axis products, squared fractions, scaled position.
    logic [31:0] hx_reg [2], hy_reg [2], hz_reg [2];
    logic [31:0] hs_reg;
    logic [15:0] f_reg [3];
    logic [15:0] f2_reg [3];
    oct_bus_t    bus_a_reg;
    // Stage B: pre-mix hashes, weights.
    logic [31:0] hb_reg [8];
    logic [WGT_W-1:0] wb_reg [3];
    oct_bus_t    bus_b_reg;
    // Stage C: mixed hashes.
    logic [31:0] hc_reg [8];
    logic [WGT_W-1:0] wc_reg [3];
    oct_bus_t    bus_c_reg;
    // Stage D: x blends.
    logic [CV_W-1:0] dx_reg [4];
    logic [WGT_W-1:0] wd_reg [2];
    oct_bus_t    bus_d_reg;
    // Stage E: y blends.
    logic [CV_W-1:0] ey_reg [2];
    logic [WGT_W-1:0] we_reg;
    oct_bus_t    bus_e_reg;
    oct_bus_t    out_reg;

    logic [31:0] ix0, iy0, iz0;
    logic [15:0] fin [3];
    logic [31:0] fsq [3];
    logic [31:0] hsum [8];
    logic [33:0] wprod [3];
    logic [CV_W-1:0] cv [8];
    logic [CV_W-1:0] vval;
    logic [ACC_W-1:0] acc_next;

    assign ix0 = in_bus.px[POS_W-1:FRAC_BITS];
    assign iy0 = in_bus.py[POS_W-1:FRAC_BITS];
    assign iz0 = in_bus.pz[POS_W-1:FRAC_BITS];
    assign fin[0] = in_bus.px[FRAC_BITS-1:0];
    assign fin[1] = in_bus.py[FRAC_BITS-1:0];
    assign fin[2] = in_bus.pz[FRAC_BITS-1:0];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            fsq[a]   = 32'(fin[a]) * 32'(fin[a]);
            wprod[a] = 34'(f2_reg[a]) * (34'(3 << FRAC_BITS) - 34'({f_reg[a], 1'b0}));
        end
        for (int c = 0; c < 8; c++)
        begin
            hsum[c] = hx_reg[c & 1] + hy_reg[(c >> 1) & 1] + hz_reg[(c >> 2) & 1] + hs_reg;
            cv[c]   = hc_reg[c][CV_W-1:0] ^ {8'b0, hc_reg[c][31:16]};
        end
        vval     = blend(ey_reg[0], ey_reg[1], we_reg);
        acc_next = active ? ({bus_e_reg.acc[ACC_W-2:0], 1'b0} + ACC_W'(vval))
                          : bus_e_reg.acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[4:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hx_reg[0] <= ix0 * HASH_MUL_X;
            hx_reg[1] <= (ix0 + 32'd1) * HASH_MUL_X;
            hy_reg[0] <= iy0 * HASH_MUL_Y;
            hy_reg[1] <= (iy0 + 32'd1) * HASH_MUL_Y;
            hz_reg[0] <= iz0 * HASH_MUL_Z;
            hz_reg[1] <= (iz0 + 32'd1) * HASH_MUL_Z;
            hs_reg    <= seed * HASH_MUL_S;
            for (int a = 0; a < 3; a++)
            begin
                f_reg[a]  <= fin[a];
                f2_reg[a] <= fsq[a][31:16];
                wb_reg[a] <= wprod[a][32:16];
            end
            bus_a_reg.px  <= scale_pos(in_bus.px);
            bus_a_reg.py  <= scale_pos(in_bus.py);
            bus_a_reg.pz  <= scale_pos(in_bus.pz);
            bus_a_reg.acc <= in_bus.acc;

            for (int c = 0; c < 8; c++)
            begin
                hb_reg[c] <= hsum[c] ^ (hsum[c] >> 13);
                hc_reg[c] <= hb_reg[c] * HASH_MIX;
            end
            bus_b_reg <= bus_a_reg;

            wc_reg    <= wb_reg;
            bus_c_reg <= bus_b_reg;

            for (int j = 0; j < 4; j++)
            begin
                dx_reg[j] <= blend(cv[2*j], cv[2*j+1], wc_reg[0]);
            end
            wd_reg[0] <= wc_reg[1];
            wd_reg[1] <= wc_reg[2];
            bus_d_reg <= bus_c_reg;

            ey_reg[0] <= blend(dx_reg[0], dx_reg[1], wd_reg[0]);
            ey_reg[1] <= blend(dx_reg[2], dx_reg[3], wd_reg[0]);
            we_reg    <= wd_reg[1];
            bus_e_reg <= bus_d_reg;

            out_reg.px  <= bus_e_reg.px;
            out_reg.py  <= bus_e_reg.py;
            out_reg.pz  <= bus_e_reg.pz;
            out_reg.acc <= acc_next;
        end
    end

    assign out_vld = vld_reg[5];
    assign out_bus = out_reg;

endmodule

`default_nettype wire

// ===== hdl/fbm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for the normalization.
// Depends on fbm_pkg.
`default_nettype none

module fbm_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_vld,
    input  logic [fbm_pkg::ACC_W-1:0] acc,
    input  logic [31:0]               den,
    output logic                      out_vld,
    output logic [fbm_pkg::QUO_W-1:0] quo
);
    import fbm_pkg::*;

    logic [QUO_W-1:0] vld_reg;
    logic [31:0]      rem_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [32:0]      trial [QUO_W];
    logic [QUO_W-1:0] ge;

    // The numerator is acc shifted up by 16; since acc never exceeds den the
    // first step sees acc itself and later steps shift in zeros.
    always_comb
    begin
        for (int j = 0; j < QUO_W; j++)
        begin
            trial[j] = (j == 0) ? {1'b0, acc} : {rem_reg[(j == 0) ? 0 : j-1], 1'b0};
            ge[j]    = trial[j] >= {1'b0, den};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[QUO_W-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < QUO_W; j++)
            begin
                rem_reg[j] <= ge[j] ? 32'(trial[j] - {1'b0, den}) : trial[j][31:0];
                quo_reg[j] <= (j == 0) ? QUO_W'(ge[j])
                                       : {quo_reg[(j == 0) ? 0 : j-1][QUO_W-2:0], ge[j]};
            end
        end
    end

    assign out_vld = vld_reg[QUO_W-1];
    assign quo     = quo_reg[QUO_W-1];

endmodule

`default_nettype wire

// ===== hdl/value_noise_fbm_3d_top.sv =====
// Top level of the 3D fractal value noise block: config registers, octave chain,
// divider and output register. Depends on fbm_pkg, fbm_octave and fbm_div.
//
//   Channel  | Handshake            | Payload
//   ---------+----------------------+------------------------------
//   input    | in_valid / in_stall  | pos_x, pos_y, pos_z (Q16.16)
//   output   | out_valid / out_stall| noise_value (Q0.16)
//   config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One transaction is accepted every cycle while in_stall is low. A transaction
// passes 67 registers: one input register, six stages for each of the eight
// octave units, seventeen divider stages and the output register.
// Reset clears all valid bits and loads the seed with 0 and the octave count with 3.
// The whole pipeline advances together; in_stall is raised only while a result
// waits in the output register and the consumer stalls it.
`default_nettype none

module value_noise_fbm_3d_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        noise_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import fbm_pkg::*;

    logic [31:0] seed_reg;
    logic [3:0]  oct_cnt_reg;
    logic [31:0] oct_seed_reg [MAX_OCTAVES];
    logic [MAX_OCTAVES-1:0] active_reg;
    logic [31:0] den_reg;
    logic [3:0]  n_eff;
    logic [MAX_OCTAVES:0] mask_next;

    logic        adv;
    logic        in_vld_reg;
    oct_bus_t    in_bus_reg;
    logic        oct_vld [MAX_OCTAVES+1];
    oct_bus_t    oct_bus [MAX_OCTAVES+1];
    logic        div_vld;
    logic [QUO_W-1:0] quo;
    logic        out_vld_reg;
    logic [15:0] noise_reg;

    // The whole pipeline moves whenever the output register is free or drained.
    assign adv       = !out_vld_reg || !out_stall;
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg    <= '0;
            oct_cnt_reg <= 4'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_NOISE_SEED:   seed_reg    <= cfg_data;
                REG_OCTAVE_COUNT: oct_cnt_reg <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    // Effective octave count is clamped to 1..MAX_OCTAVES.
    always_comb
    begin
        if (oct_cnt_reg == 4'd0)
            n_eff = 4'd1;
        else if (oct_cnt_reg > 4'(MAX_OCTAVES))
            n_eff = 4'(MAX_OCTAVES);
        else
            n_eff = oct_cnt_reg;
        mask_next = (MAX_OCTAVES+1)'((MAX_OCTAVES+1)'(1) << n_eff) - (MAX_OCTAVES+1)'(1);
    end

    // Derived per-octave settings are refreshed every cycle. The user must change the
    // configuration only while the pipeline is empty; the block does not enforce it.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_OCTAVES; k++)
        begin
            oct_seed_reg[k] <= seed_reg + 32'(k) * SEED_STEP;
        end
        active_reg <= mask_next[MAX_OCTAVES-1:0];
        den_reg    <= 32'(mask_next[7:0]) * 32'(CORNER_MAX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_vld_reg <= in_valid;
        end
    end

    // Sign extension keeps the floor and the 16 fraction bits of the input.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_bus_reg.px  <= POS_W'(pos_x);
            in_bus_reg.py  <= POS_W'(pos_y);
            in_bus_reg.pz  <= POS_W'(pos_z);
            in_bus_reg.acc <= '0;
        end
    end

    assign oct_vld[0] = in_vld_reg;
    assign oct_bus[0] = in_bus_reg;

    // Each octave unit adds its value Horner style (acc = 2*acc + v), so the
    // oldest octave ends up with the largest weight. Inactive octaves pass the
    // accumulator unchanged.
    for (genvar k = 0; k < MAX_OCTAVES; k++)
    begin : g_oct
        fbm_octave u_oct (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .in_vld  (oct_vld[k]),
            .in_bus  (oct_bus[k]),
            .seed    (oct_seed_reg[k]),
            .active  (active_reg[k]),
            .out_vld (oct_vld[k+1]),
            .out_bus (oct_bus[k+1])
        );
    end

    fbm_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (oct_vld[MAX_OCTAVES]),
        .acc     (oct_bus[MAX_OCTAVES].acc),
        .den     (den_reg),
        .out_vld (div_vld),
        .quo     (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= div_vld;
        end
    end

    // A full-scale quotient of exactly one saturates to the largest code.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            noise_reg <= quo[QUO_W-1] ? 16'hffff : quo[15:0];
        end
    end

    assign out_valid   = out_vld_reg;
    assign noise_value = noise_reg;

endmodule

`default_nettype wire

// ===== hdl/fbm_chk.sv =====
// Port-level checker for the fractal noise top level, bound to it below.
// Depends only on the top level's port list.
`default_nettype none

module fbm_chk (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_stall,
    input wire        out_valid,
    input wire        out_stall,
    input wire [15:0] noise_value,
    input wire        cfg_valid,
    input wire        cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(noise_value))
        else $error("stalled result changed");

    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result right after reset");

endmodule

bind value_noise_fbm_3d_top fbm_chk u_fbm_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .noise_value (noise_value),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready)
);

`default_nettype wire
